### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the fault lifecycle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/diag_flc_pkg.sv
// Types and next-state function of the diagnostic fault lifecycle block.
`default_nettype none

package diag_flc_pkg;

  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PENDING1  = 3'd1,
    ST_PENDING2  = 3'd2,
    ST_CONFIRMED = 3'd3,
    ST_HIST_ON   = 3'd4,
    ST_HIST_OFF  = 3'd5
  } fault_state_e;

  typedef struct packed {
    fault_state_e nxt;
    logic         rec;
    logic         clr;
  } step_t;

  // One lifecycle step; unused codes behave as ok.
  function automatic step_t fault_step(
    input fault_state_e      cur,
    input logic [CountW-1:0] dc,
    input logic              cf,
    input logic [CountW-1:0] thr,
    input logic [CountW-1:0] wuc
  );
    step_t r;
    logic  dc_zero;
    dc_zero = (dc == '0);
    r.nxt   = cur;
    r.rec   = 1'b0;
    r.clr   = 1'b0;
    case (cur)
      ST_PENDING1: begin
        if (dc_zero) begin
          r.nxt = ST_OK;
        end else if (cf) begin
          r.nxt = ST_CONFIRMED;
          r.rec = 1'b1;
        end
      end
      ST_PENDING2: begin
        if (dc_zero) begin
          r.nxt = ST_HIST_OFF;
        end else if (cf) begin
          r.nxt = ST_CONFIRMED;
        end
      end
      ST_CONFIRMED: begin
        if (dc_zero) begin
          r.nxt = ST_HIST_OFF;
        end else if (dc < thr) begin
          r.nxt = ST_HIST_ON;
        end
      end
      ST_HIST_ON: begin
        if (dc_zero) begin
          r.nxt = ST_HIST_OFF;
        end else if (dc == thr) begin
          r.nxt = ST_CONFIRMED;
        end
      end
      ST_HIST_OFF: begin
        if (!dc_zero) begin
          r.nxt = cf ? ST_CONFIRMED : ST_PENDING2;
        end else if (wuc == '0) begin
          r.nxt = ST_OK;
          r.clr = 1'b1;
        end
      end
      default: begin
        r.nxt = ST_OK;
        if (!dc_zero && !cf) begin
          r.nxt = ST_PENDING1;
        end else if (cf) begin
          r.nxt = ST_CONFIRMED;
          r.rec = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/diag_fault_lifecycle_fsm_top.sv
// Diagnostic fault lifecycle state machine: per-fault state table and result path.
//
// Keeps one lifecycle state (ok, pending1, pending2, confirmed, history_on,
// history_off) for each of up to 16 faults, all ok after reset. Each input
// beat names a fault and carries its drive-cycle count, confirm flag, no-heal
// threshold and warm-up count; the block applies the lifecycle rules, writes
// the new state back and returns one result beat with the fault id, the new
// state and the record/clear event flags. A beat passes through the input
// register, then the state table read-modify-write feeding the result
// register, and one beat is accepted every cycle while results are taken.
// The state table is read and written in the same cycle, so
// consecutive beats for the same fault always see each other's updates. An
// index at or above NUM_FAULTS leaves the table alone and reports ok with
// no events. No clearing pass is needed: reset clears the table at once.
`default_nettype none

`include "assert_macros.svh"

module diag_fault_lifecycle_fsm_top
  import diag_flc_pkg::*;
#(
  parameter int unsigned NUM_FAULTS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [IdxW-1:0]   fault_index_i,
  input  wire logic [CountW-1:0] drive_cycle_count_i,
  input  wire logic              confirm_flag_i,
  input  wire logic [CountW-1:0] heal_threshold_i,
  input  wire logic [CountW-1:0] warmup_count_i,

  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [IdxW-1:0]        fault_id_o,
  output logic [2:0]             new_state_o,
  output logic                   record_event_o,
  output logic                   clear_event_o
);

  // Only indexes reachable through the 4-bit field need storage.
  localparam int unsigned MaxIdx = 2 ** IdxW;
  localparam int unsigned Depth  = (NUM_FAULTS < MaxIdx) ? NUM_FAULTS : MaxIdx;
  localparam int unsigned TabW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmpW   = 10;

  // Input register
  logic              s1_valid_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic [CountW-1:0] s1_dc_q;
  logic              s1_cf_q;
  logic [CountW-1:0] s1_thr_q;
  logic [CountW-1:0] s1_wuc_q;

  // Result register
  logic              out_valid_q;
  logic [IdxW-1:0]   out_id_q;
  fault_state_e      out_state_q;
  logic              out_rec_q;
  logic              out_clr_q;

  fault_state_e      state_q [Depth];

  logic              s2_adv;
  logic              in_acc;
  logic              s1_in_range;
  logic [TabW-1:0]   s1_tab_idx;
  fault_state_e      cur_state;
  step_t             step;

  // Advance into the result register when it is empty or being drained.
  assign s2_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign s1_in_range = (CmpW'(s1_idx_q) < CmpW'(NUM_FAULTS));
  assign s1_tab_idx  = s1_idx_q[TabW-1:0];

  always_comb begin
    cur_state = ST_OK;
    if (s1_in_range) begin
      cur_state = state_q[s1_tab_idx];
    end
    step = fault_step(cur_state, s1_dc_q, s1_cf_q, s1_thr_q, s1_wuc_q);
    // Out of range: report ok, drop the events.
    if (!s1_in_range) begin
      step = '{nxt: ST_OK, rec: 1'b0, clr: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Hold the payload until the next beat arrives.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q <= fault_index_i;
      s1_dc_q  <= drive_cycle_count_i;
      s1_cf_q  <= confirm_flag_i;
      s1_thr_q <= heal_threshold_i;
      s1_wuc_q <= warmup_count_i;
    end
  end

  // State table: written only when a beat moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        state_q[i] <= ST_OK;
      end
    end else if (s2_adv && s1_in_range) begin
      state_q[s1_tab_idx] <= step.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_id_q    <= s1_idx_q;
      out_state_q <= step.nxt;
      out_rec_q   <= step.rec;
      out_clr_q   <= step.clr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fault_id_o     = out_id_q;
  assign new_state_o    = out_state_q;
  assign record_event_o = out_rec_q;
  assign clear_event_o  = out_clr_q;

  // Assertions
  logic            out_in_range;
  logic [TabW-1:0] out_tab_idx;

  assign out_in_range = (CmpW'(out_id_q) < CmpW'(NUM_FAULTS));
  assign out_tab_idx  = out_id_q[TabW-1:0];

  `ASSERT_IMPLIES(a_rec_confirmed, clk_i, rst_ni, out_valid_q && out_rec_q,
                  out_state_q == ST_CONFIRMED && !out_clr_q,
                  "record event without entering confirmed")
  `ASSERT_IMPLIES(a_clr_ok, clk_i, rst_ni, out_valid_q && out_clr_q,
                  out_state_q == ST_OK, "clear event without returning to ok")
  `ASSERT_IMPLIES(a_table_matches, clk_i, rst_ni, out_valid_q && out_in_range,
                  state_q[out_tab_idx] == out_state_q,
                  "state table disagrees with pending result")
  `ASSERT_IMPLIES(a_oob_result, clk_i, rst_ni, out_valid_q && !out_in_range,
                  out_state_q == ST_OK && !out_rec_q && !out_clr_q,
                  "out-of-range fault reported a transition")

endmodule

`default_nettype wire

### tb/sv/diag_fault_lifecycle_fsm_top_tb.sv
// Self-checking testbench for the diagnostic fault lifecycle state machine.
module diag_fault_lifecycle_fsm_top_tb;
  import diag_flc_pkg::*;

  localparam int unsigned NumFaults  = 16;
  localparam int          RandBeats  = 1500;
  localparam int          BatchLen   = 64;
  localparam int          PressureAt = 700;
  localparam int          HoldCycles = 200;
  localparam int          CycleLimit = 600000;

  // Next state of one fault as worked out here, with its event flags.
  typedef struct packed {
    fault_state_e nxt;
    logic         rec;
    logic         clr;
  } flc_verdict_t;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [IdxW-1:0] id;
    logic [2:0]      st;
    logic            rec;
    logic            clr;
  } flc_result_t;

  // One row of the directed table; chk marks a row whose result is typed in.
  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] dc;
    logic              cf;
    logic [CountW-1:0] thr;
    logic [CountW-1:0] wuc;
    logic              chk;
    logic [2:0]        st;
    logic              rec;
    logic              clr;
  } flc_row_t;

  localparam int DirRows = 26;

  // Walk every change of state: reset state and extremes on faults 0 and 15, the
  // lifecycle through every state on fault 2, and confirmation straight from ok
  // with a zero threshold on fault 7.
  flc_row_t dir_table [DirRows] = '{
    //  idx    dc    cf    thr   wuc   chk   st            rec   clr
    '{4'd0,  8'd0,   1'b0, 8'd0,   8'd0,   1'b1, ST_OK,        1'b0, 1'b0},
    '{4'd15, 8'd255, 1'b1, 8'd255, 8'd255, 1'b1, ST_CONFIRMED, 1'b1, 1'b0},
    '{4'd15, 8'd255, 1'b0, 8'd255, 8'd255, 1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd15, 8'd0,   1'b1, 8'd255, 8'd255, 1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd15, 8'd0,   1'b0, 8'd0,   8'd255, 1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd15, 8'd0,   1'b0, 8'd255, 8'd0,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd5,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd0,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd3,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd3,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd3,   1'b1, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd9,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd4,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd7,   1'b1, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd5,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd4,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd0,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd9,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd9,   1'b1, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd0,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd1,   1'b1, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd0,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd9,   1'b0, 8'd5,   8'd1,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd2,  8'd0,   1'b0, 8'd5,   8'd0,   1'b0, ST_OK,        1'b0, 1'b0},
    '{4'd7,  8'd1,   1'b1, 8'd0,   8'd0,   1'b1, ST_CONFIRMED, 1'b1, 1'b0},
    '{4'd7,  8'd1,   1'b0, 8'd0,   8'd0,   1'b0, ST_OK,        1'b0, 1'b0}
  };

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              in_valid_i          = 1'b0;
  logic              in_ready_o;
  logic [IdxW-1:0]   fault_index_i       = '0;
  logic [CountW-1:0] drive_cycle_count_i = '0;
  logic              confirm_flag_i      = 1'b0;
  logic [CountW-1:0] heal_threshold_i    = '0;
  logic [CountW-1:0] warmup_count_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i         = 1'b0;
  logic [IdxW-1:0]   fault_id_o;
  logic [2:0]        new_state_o;
  logic              record_event_o;
  logic              clear_event_o;

  // Lifecycle table as predicted here, and the results still owed by the block.
  fault_state_e fault_tbl [NumFaults];
  flc_result_t  lifecycle_updates_q [$];

  int beats_in     = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cycle_count  = 0;
  int rec_seen     = 0;
  int clr_seen     = 0;
  int state_hits [8];
  int idle_mode    = 0;   // 0: no idling, 1: sparse gaps, 2: heavy gaps

  diag_fault_lifecycle_fsm_top #(
    .NUM_FAULTS(NumFaults)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .fault_index_i      (fault_index_i),
    .drive_cycle_count_i(drive_cycle_count_i),
    .confirm_flag_i     (confirm_flag_i),
    .heal_threshold_i   (heal_threshold_i),
    .warmup_count_i     (warmup_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .fault_id_o         (fault_id_o),
    .new_state_o        (new_state_o),
    .record_event_o     (record_event_o),
    .clear_event_o      (clear_event_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance one fault through the lifecycle rules.
  function automatic flc_verdict_t lifecycle_step(
    input fault_state_e      cur,
    input logic [CountW-1:0] dc,
    input logic              cf,
    input logic [CountW-1:0] thr,
    input logic [CountW-1:0] wuc
  );
    flc_verdict_t v;
    v.nxt = cur;
    v.rec = 1'b0;
    v.clr = 1'b0;
    case (cur)
      ST_PENDING1: begin
        if (dc == 0) begin
          v.nxt = ST_OK;
        end else if (cf) begin
          v.nxt = ST_CONFIRMED;
          v.rec = 1'b1;
        end
      end
      ST_PENDING2: begin
        if (dc == 0) begin
          v.nxt = ST_HIST_OFF;
        end else if (cf) begin
          v.nxt = ST_CONFIRMED;
        end
      end
      ST_CONFIRMED: begin
        if (dc == 0) begin
          v.nxt = ST_HIST_OFF;
        end else if (dc < thr) begin
          v.nxt = ST_HIST_ON;
        end
      end
      ST_HIST_ON: begin
        if (dc == 0) begin
          v.nxt = ST_HIST_OFF;
        end else if (dc == thr) begin
          v.nxt = ST_CONFIRMED;
        end
      end
      ST_HIST_OFF: begin
        if (dc != 0) begin
          v.nxt = cf ? ST_CONFIRMED : ST_PENDING2;
        end else if (wuc == 0) begin
          v.nxt = ST_OK;
          v.clr = 1'b1;
        end
      end
      default: begin
        // ok, and any stray code, behaves as ok
        v.nxt = ST_OK;
        if (dc != 0 && !cf) begin
          v.nxt = ST_PENDING1;
        end else if (cf) begin
          v.nxt = ST_CONFIRMED;
          v.rec = 1'b1;
        end
      end
    endcase
    return v;
  endfunction

  // Pick a gap length for the current idling mode: mostly short, now and then long.
  function automatic int gap_cycles(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (roll < 3) return $urandom_range(10, 40);
    if (mode == 1 && roll < 20) return $urandom_range(1, 3);
    if (mode == 2 && roll < 55) return $urandom_range(1, 4);
    return 0;
  endfunction

  // Offer one beat and hold it until accepted; then log what the block owes.
  // Called at a rising edge; leaves valid high so the next beat can follow at once.
  task automatic offer_beat(input flc_row_t row);
    flc_verdict_t v;
    flc_result_t  r;
    in_valid_i          <= 1'b1;
    fault_index_i       <= row.idx;
    drive_cycle_count_i <= row.dc;
    confirm_flag_i      <= row.cf;
    heal_threshold_i    <= row.thr;
    warmup_count_i      <= row.wuc;
    do @(posedge clk_i); while (!in_ready_o);
    beats_in++;
    r.id = row.idx;
    if (row.idx < NumFaults) begin
      v = lifecycle_step(fault_tbl[row.idx], row.dc, row.cf, row.thr, row.wuc);
      fault_tbl[row.idx] = v.nxt;
      r.st  = v.nxt;
      r.rec = v.rec;
      r.clr = v.clr;
    end else begin
      r.st  = ST_OK;
      r.rec = 1'b0;
      r.clr = 1'b0;
    end
    if (row.chk) begin
      r.st  = row.st;
      r.rec = row.rec;
      r.clr = row.clr;
    end
    lifecycle_updates_q.push_back(r);
  endtask

  // Drop valid for a random stretch before the next beat.
  task automatic sender_gap();
    int n;
    n = gap_cycles(idle_mode);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Sender: reset, directed table, then random traffic biased towards long lifecycles.
  initial begin
    flc_row_t row;
    int       pick;
    foreach (fault_tbl[i]) fault_tbl[i] = ST_OK;
    foreach (state_hits[i]) state_hits[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_mode = 1;
    for (int i = 0; i < DirRows; i++) begin
      sender_gap();
      offer_beat(dir_table[i]);
    end

    for (int i = 0; i < RandBeats; i++) begin
      if (i % BatchLen == 0) idle_mode = $urandom_range(0, 2);
      row = '0;
      // Keep most beats on a few faults so their lifecycles go deep.
      if ($urandom_range(0, 9) < 8) row.idx = IdxW'($urandom_range(0, 3));
      else row.idx = IdxW'($urandom_range(0, 15));
      pick = $urandom_range(0, 9);
      if (pick == 0) row.thr = 8'd0;
      else if (pick == 1) row.thr = 8'd255;
      else if (pick < 6) row.thr = 8'($urandom_range(1, 12));
      else row.thr = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 3) row.dc = 8'd0;
      else if (pick < 5) row.dc = row.thr;
      else if (pick == 5) row.dc = 8'd255;
      else if (pick < 8) row.dc = 8'($urandom_range(1, 12));
      else row.dc = 8'($urandom_range(0, 255));
      row.cf  = ($urandom_range(0, 2) == 0);
      row.wuc = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      sender_gap();
      offer_beat(row);
    end
    in_valid_i <= 1'b0;

    while (lifecycle_updates_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d beats in and %0d results out, %0d record and %0d clear events.",
             beats_in, results_seen, rec_seen, clr_seen);
    $display("States reported: ok %0d, pending1 %0d, pending2 %0d,",
             state_hits[ST_OK], state_hits[ST_PENDING1], state_hits[ST_PENDING2]);
    $display("  confirmed %0d, hist_on %0d, hist_off %0d.",
             state_hits[ST_CONFIRMED], state_hits[ST_HIST_ON], state_hits[ST_HIST_OFF]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Compare one result beat against the oldest owed result.
  task automatic check_result();
    flc_result_t e;
    flc_result_t a;
    a = '{fault_id_o, new_state_o, record_event_o, clear_event_o};
    results_seen++;
    if (a.rec) rec_seen++;
    if (a.clr) clr_seen++;
    state_hits[a.st]++;
    if (lifecycle_updates_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result beat: fault_id %0d new_state %0d rec %0b clr %0b",
                 a.id, a.st, a.rec, a.clr);
      return;
    end
    e = lifecycle_updates_q.pop_front();
    if (a.id !== e.id || a.st !== e.st || a.rec !== e.rec || a.clr !== e.clr) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d (exp/got): id %0d/%0d state %0d/%0d %s",
                 results_seen, e.id, a.id, e.st, a.st,
                 $sformatf("rec %0b/%0b clr %0b/%0b", e.rec, a.rec, e.clr, a.clr));
    end
  endtask

  // Receiver: check every beat taken, and stall at random; once, hold off long
  // enough for the block to back up and drop its input ready.
  initial begin
    int stall_left;
    int hold_left;
    bit pressure_done;
    stall_left    = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!pressure_done && results_seen >= PressureAt) begin
        pressure_done = 1'b1;
        hold_left     = HoldCycles;
        out_ready_i   <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left  = gap_cycles(idle_mode);
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, lifecycle_updates_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
